### design/pbmp_pkg.sv
// Shared types, character codes and result helpers for the PBM P1 stream parser.
package pbmp_pkg;

  // Default largest accepted image dimension.
  localparam int unsigned MaxDimDefault = 4096;

  // Fixed widths of the result fields.
  localparam int unsigned PosW = 12;
  localparam int unsigned DimW = 13;

  // Character codes used by the parser.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_BAD_MAGIC = 2'd0,
    ERR_BAD_DIM   = 2'd1,
    ERR_BAD_PIXEL = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  // One result transaction.
  typedef struct packed {
    kind_e            kind;
    logic             pixel_value;
    logic [PosW-1:0]  column;
    logic [PosW-1:0]  row;
    logic [DimW-1:0]  image_width;
    logic [DimW-1:0]  image_height;
    err_e             error_code;
    logic             image_done;
    logic             last_of_run;
  } res_t;

  // Whitespace: space, TAB, LF, VT, FF and CR.
  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Builds a result with the run marker cleared.
  function automatic res_t mk_res(kind_e k, logic pix, logic [PosW-1:0] col,
                                  logic [PosW-1:0] row, logic [DimW-1:0] w,
                                  logic [DimW-1:0] h, err_e e, logic done);
    res_t r;
    r.kind         = k;
    r.pixel_value  = pix;
    r.column       = col;
    r.row          = row;
    r.image_width  = w;
    r.image_height = h;
    r.error_code   = e;
    r.image_done   = done;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

### design/pbmp_core.sv
// Parser state and the per-byte decision logic of the PBM P1 stream parser.
module pbmp_core
  import pbmp_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output res_t        res_first_o,
  output res_t        res_second_o,
  output logic [1:0]  res_count_o
);

  // Accumulators hold up to MaxDim + 1; counters hold up to MaxDim.
  localparam int unsigned AccW = $clog2(MaxDim + 2);
  localparam int unsigned CntW = $clog2(MaxDim + 1);
  localparam logic [AccW+3:0] SatVal = (AccW + 4)'(MaxDim + 1);
  localparam logic [AccW-1:0] MaxAcc = AccW'(MaxDim);

  typedef enum logic [10:0] {
    PH_MAGIC_P   = 11'b000_0000_0001,
    PH_MAGIC_ONE = 11'b000_0000_0010,
    PH_MAGIC_END = 11'b000_0000_0100,
    PH_W_START   = 11'b000_0000_1000,
    PH_W_SIGN    = 11'b000_0001_0000,
    PH_W_DIGITS  = 11'b000_0010_0000,
    PH_H_START   = 11'b000_0100_0000,
    PH_H_SIGN    = 11'b000_1000_0000,
    PH_H_DIGITS  = 11'b001_0000_0000,
    PH_PIXELS    = 11'b010_0000_0000,
    PH_HALT      = 11'b100_0000_0000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              comment_q, comment_d;
  logic              neg_q, neg_d;
  logic [AccW-1:0]   wacc_q, wacc_d;
  logic [AccW-1:0]   hacc_q, hacc_d;
  logic [CntW-1:0]   col_q, col_d;
  logic [CntW-1:0]   row_q, row_d;

  // Decimal accumulate with saturation at MaxDim + 1.
  function automatic logic [AccW-1:0] acc_next(logic [AccW-1:0] a, logic [3:0] d);
    logic [AccW+3:0] v;
    v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{AccW{1'b0}}, d};
    if (v > SatVal) begin
      v = SatVal;
    end
    return v[AccW-1:0];
  endfunction

  function automatic logic dim_ok(logic neg, logic [AccW-1:0] a);
    return !neg && (a != '0) && (a <= MaxAcc);
  endfunction

  // Position counters are reported modulo 4096.
  function automatic logic [PosW-1:0] to_pos(logic [CntW-1:0] x);
    logic [CntW+PosW-1:0] e;
    e = {{PosW{1'b0}}, x};
    return e[PosW-1:0];
  endfunction

  function automatic logic [DimW-1:0] to_dim(logic [AccW-1:0] x);
    logic [AccW+DimW-1:0] e;
    e = {{DimW{1'b0}}, x};
    return e[DimW-1:0];
  endfunction

  function automatic res_t err_res(err_e e);
    return mk_res(KIND_ERROR, 1'b0, '0, '0, '0, '0, e, 1'b0);
  endfunction

  // Per-byte decision: at most a header followed by a pixel or an error.
  always_comb begin
    phase_e          ph;
    logic [7:0]      c;
    logic            dig;
    logic [3:0]      dval;
    logic [CntW-1:0] col;
    logic [CntW-1:0] row;
    logic [CntW-1:0] col_inc;
    logic [CntW-1:0] row_inc;
    logic            done;
    res_t            hdr;
    res_t            act;
    logic            hdr_vld;
    logic            act_vld;

    c       = data_byte_i;
    dig     = is_digit(c);
    dval    = c[3:0];
    ph      = phase_q;
    col     = col_q;
    row     = row_q;
    col_inc = col_q + 1'b1;
    row_inc = row_q + 1'b1;
    done    = 1'b0;
    hdr     = mk_res(KIND_HEADER, 1'b0, '0, '0, to_dim(wacc_q), to_dim(hacc_q),
                     ERR_BAD_MAGIC, 1'b0);
    act     = err_res(ERR_BAD_MAGIC);
    hdr_vld = 1'b0;
    act_vld = 1'b0;

    phase_d   = phase_q;
    comment_d = comment_q;
    neg_d     = neg_q;
    wacc_d    = wacc_q;
    hacc_d    = hacc_q;
    col_d     = col_q;
    row_d     = row_q;

    if (phase_q == PH_HALT) begin
      // Nothing more happens until reset.
    end else if (end_of_stream_i) begin
      comment_d = 1'b0;
      phase_d   = PH_HALT;
      act_vld   = 1'b1;
      if ((phase_q == PH_MAGIC_P) || (phase_q == PH_MAGIC_ONE)) begin
        act = err_res(ERR_BAD_MAGIC);
      end else if ((phase_q == PH_H_DIGITS) && dim_ok(neg_q, hacc_q)) begin
        hdr_vld = 1'b1;
        act     = err_res(ERR_TRUNCATED);
      end else if (phase_q == PH_PIXELS) begin
        act = err_res(ERR_TRUNCATED);
      end else begin
        act = err_res(ERR_BAD_DIM);
      end
    end else if (comment_q) begin
      if (c == CH_LF) begin
        comment_d = 1'b0;
      end
    end else begin
      // A valid number ends at this byte, which then starts the next step.
      if ((ph == PH_W_DIGITS) && !dig && dim_ok(neg_q, wacc_q)) begin
        neg_d = 1'b0;
        ph    = PH_H_START;
      end
      if ((ph == PH_H_DIGITS) && !dig && dim_ok(neg_q, hacc_q)) begin
        hdr_vld = 1'b1;
        ph      = PH_PIXELS;
        col     = '0;
        row     = '0;
        col_inc = CntW'(1);
        row_inc = CntW'(1);
      end
      phase_d = ph;
      col_d   = col;
      row_d   = row;

      case (ph)
        PH_MAGIC_P: begin
          if (is_space(c)) begin
          end else if (c == CH_HASH) begin
            comment_d = 1'b1;
          end else if (c == CH_P) begin
            phase_d = PH_MAGIC_ONE;
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_MAGIC);
            phase_d = PH_HALT;
          end
        end
        PH_MAGIC_ONE: begin
          if (c == CH_ONE) begin
            phase_d = PH_MAGIC_END;
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_MAGIC);
            phase_d = PH_HALT;
          end
        end
        PH_MAGIC_END: begin
          if (is_space(c)) begin
            phase_d = PH_W_START;
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_MAGIC);
            phase_d = PH_HALT;
          end
        end
        PH_W_START, PH_H_START: begin
          if (is_space(c)) begin
          end else if (c == CH_HASH) begin
            comment_d = 1'b1;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            if (c == CH_MINUS) begin
              neg_d = 1'b1;
            end
            phase_d = (ph == PH_W_START) ? PH_W_SIGN : PH_H_SIGN;
          end else if (dig) begin
            if (ph == PH_W_START) begin
              wacc_d  = AccW'(dval);
              phase_d = PH_W_DIGITS;
            end else begin
              hacc_d  = AccW'(dval);
              phase_d = PH_H_DIGITS;
            end
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_DIM);
            phase_d = PH_HALT;
          end
        end
        PH_W_SIGN, PH_H_SIGN: begin
          if (dig) begin
            if (ph == PH_W_SIGN) begin
              wacc_d  = AccW'(dval);
              phase_d = PH_W_DIGITS;
            end else begin
              hacc_d  = AccW'(dval);
              phase_d = PH_H_DIGITS;
            end
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_DIM);
            phase_d = PH_HALT;
          end
        end
        PH_W_DIGITS: begin
          if (dig) begin
            wacc_d = acc_next(wacc_q, dval);
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_DIM);
            phase_d = PH_HALT;
          end
        end
        PH_H_DIGITS: begin
          if (dig) begin
            hacc_d = acc_next(hacc_q, dval);
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_DIM);
            phase_d = PH_HALT;
          end
        end
        PH_PIXELS: begin
          if (is_space(c)) begin
          end else if (c == CH_HASH) begin
            comment_d = 1'b1;
          end else if ((c == CH_ZERO) || (c == CH_ONE)) begin
            done    = (AccW'(col_inc) >= wacc_q) && (AccW'(row_inc) >= hacc_q);
            act_vld = 1'b1;
            act     = mk_res(KIND_PIXEL, c[0], to_pos(col), to_pos(row), '0, '0,
                             ERR_BAD_MAGIC, done);
            if (done) begin
              phase_d = PH_HALT;
            end else if (AccW'(col_inc) >= wacc_q) begin
              col_d = '0;
              row_d = row_inc;
            end else begin
              col_d = col_inc;
            end
          end else begin
            act_vld = 1'b1;
            act     = err_res(ERR_BAD_PIXEL);
            phase_d = PH_HALT;
          end
        end
        default: begin
        end
      endcase
    end

    // Order the results and mark the last one of this byte.
    res_count_o              = {1'b0, hdr_vld} + {1'b0, act_vld};
    res_first_o              = hdr_vld ? hdr : act;
    res_first_o.last_of_run  = !(hdr_vld && act_vld);
    res_second_o             = act;
    res_second_o.last_of_run = 1'b1;
  end

  // Parser state advances only when the byte in the input register is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC_P;
      comment_q <= 1'b0;
      neg_q     <= 1'b0;
      wacc_q    <= '0;
      hacc_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      comment_q <= comment_d;
      neg_q     <= neg_d;
      wacc_q    <= wacc_d;
      hacc_q    <= hacc_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

### design/pbm_ascii_stream_parser.sv
// Top level of the PBM P1 stream parser: input register, parser core, result queue.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_stall_o   | data_byte_i, end_of_stream_i
//  out     | from block| out_valid_o / out_stall_i | kind, pixel, position, size, error
//
// A byte is taken into the input register when it is accepted and is decoded into a
// two-entry result queue once the queue has room for all it yields; the head of that
// queue drives the output port. One byte is accepted per cycle while in_stall_o is low.
// The byte that yields two results (header followed by a pixel or an error) waits in the
// input register until both queue entries are free. Reset clears the parser state and
// empties both registers.
// While out_stall_i is high the head result holds, and input is stalled once the queue
// has no room for what the pending byte produces.
module pbm_ascii_stream_parser
  import pbmp_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_stream_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic             pixel_value_o,
  output logic [PosW-1:0]  column_o,
  output logic [PosW-1:0]  row_o,
  output logic [DimW-1:0]  image_width_o,
  output logic [DimW-1:0]  image_height_o,
  output logic [1:0]       error_code_o,
  output logic             image_done_o,
  output logic             last_of_run_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic        in_accept;
  logic        go;

  res_t        res_first;
  res_t        res_second;
  logic [1:0]  res_count;

  res_t        q_ent_q [2];
  res_t        q_ent_d [2];
  logic [1:0]  q_cnt_q, q_cnt_d;
  logic        pop;
  logic [1:0]  keep;
  logic [1:0]  n_push;

  // Input register.
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = in_vld_q && !go;
  assign in_vld_d   = in_accept || (in_vld_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_eos_q  <= end_of_stream_i;
    end
  end

  // Decode of the registered byte.
  pbmp_core #(
    .MaxDim (MaxDim)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (go),
    .data_byte_i     (in_byte_q),
    .end_of_stream_i (in_eos_q),
    .res_first_o     (res_first),
    .res_second_o    (res_second),
    .res_count_o     (res_count)
  );

  // Result queue: the byte is decoded when everything it yields fits.
  assign pop    = (q_cnt_q != 2'd0) && !out_stall_i;
  assign keep   = q_cnt_q - {1'b0, pop};
  assign go     = in_vld_q && (({1'b0, keep} + {1'b0, res_count}) <= 3'd2);
  assign n_push = go ? res_count : 2'd0;

  always_comb begin
    q_ent_d[0] = q_ent_q[0];
    q_ent_d[1] = q_ent_q[1];
    case (keep)
      2'd0: begin
        q_ent_d[0] = res_first;
        q_ent_d[1] = res_second;
      end
      2'd1: begin
        q_ent_d[0] = pop ? q_ent_q[1] : q_ent_q[0];
        q_ent_d[1] = res_first;
      end
      default: begin
      end
    endcase
    q_cnt_d = keep + n_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else begin
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_ent_q[0] <= q_ent_d[0];
    q_ent_q[1] <= q_ent_d[1];
  end

  // Head of the queue drives the output port.
  assign out_valid_o    = (q_cnt_q != 2'd0);
  assign kind_o         = q_ent_q[0].kind;
  assign pixel_value_o  = q_ent_q[0].pixel_value;
  assign column_o       = q_ent_q[0].column;
  assign row_o          = q_ent_q[0].row;
  assign image_width_o  = q_ent_q[0].image_width;
  assign image_height_o = q_ent_q[0].image_height;
  assign error_code_o   = q_ent_q[0].error_code;
  assign image_done_o   = q_ent_q[0].image_done;
  assign last_of_run_o  = q_ent_q[0].last_of_run;

endmodule

### design/pbmp_checker.sv
// Port-level checks for the PBM P1 stream parser, attached to the top level by bind.
module pbmp_checker
  import pbmp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [7:0]       data_byte_i,
  input logic             end_of_stream_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       kind_o,
  input logic             pixel_value_o,
  input logic [PosW-1:0]  column_o,
  input logic [PosW-1:0]  row_o,
  input logic [DimW-1:0]  image_width_o,
  input logic [DimW-1:0]  image_height_o,
  input logic [1:0]       error_code_o,
  input logic             image_done_o,
  input logic             last_of_run_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(column_o)
      && $stable(row_o) && $stable(error_code_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // An error always ends the results of its byte.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR) |-> last_of_run_o)
    else $error("error result not last of its byte");

  // The final pixel ends the results of its byte.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PIXEL) && image_done_o |-> last_of_run_o)
    else $error("final pixel not last of its byte");

  // A reported header never carries a zero dimension.
  a_hdr_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEADER) |->
      (image_width_o != '0) && (image_height_o != '0))
    else $error("header with zero dimension");

endmodule

bind pbm_ascii_stream_parser pbmp_checker u_pbmp_checker (.*);
